@@ rtl/core/tbl_pkg.sv @@
`default_nettype none
package tbl_pkg;
	localparam int MaxTetsDefault   = 256;
	localparam int CoordBitsDefault = 16;
	localparam int DetW             = 56;
	localparam int WeightW          = 17;
	localparam logic OpLoad  = 1'b0;
	localparam logic OpQuery = 1'b1;
	localparam logic [16:0] WeightOne = 17'h10000;
endpackage
`default_nettype wire

@@ rtl/core/tbl_ram.sv @@
`default_nettype none
module tbl_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/tbl_det.sv @@
`default_nettype none
// Sequential 4x4 determinant over corner differences; a new start restarts it.
module tbl_det #(
	parameter int CoordBits = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic signed [CoordBits:0]  ax, ay, az, bx, by, bz, cx, cy, cz,
	output logic                            done,
	output logic signed [tbl_pkg::DetW-1:0] det
);
	import tbl_pkg::*;
	localparam int DW = CoordBits + 1;
	localparam int PW = 2 * DW + 1;

	logic [3:0] step_q;
	logic       busy_q;
	logic signed [DW-1:0] m1, m2;
	logic signed [2*DW-1:0] prod;
	logic signed [PW-1:0] minor_q;
	logic signed [DetW-1:0] acc_q;
	logic signed [DetW-1:0] term;

	// pick minor multiplier operands per step; the outer factor is picked below
	always_comb begin
		m1 = '0;
		m2 = '0;
		unique case (step_q)
			4'd0: begin m1 = by; m2 = cz; end
			4'd1: begin m1 = bz; m2 = cy; end
			4'd2: begin m1 = bx; m2 = cz; end
			4'd3: begin m1 = bz; m2 = cx; end
			4'd4: begin m1 = bx; m2 = cy; end
			4'd5: begin m1 = by; m2 = cx; end
			default: begin m1 = '0; m2 = '0; end
		endcase
	end
	assign prod = m1 * m2;

	logic signed [DW-1:0] outer;
	always_comb begin
		unique case (step_q)
			4'd2:    outer = ax;
			4'd4:    outer = ay;
			4'd6:    outer = az;
			default: outer = '0;
		endcase
	end
	assign term = DetW'(minor_q) * DetW'(outer);

	// accumulate -(ax*m0 - ay*m1 + az*m2)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				acc_q  <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				unique case (step_q)
					4'd0, 4'd2, 4'd4: minor_q <= PW'(prod);
					4'd1, 4'd3, 4'd5: minor_q <= minor_q - PW'(prod);
					default: ;
				endcase
				if (step_q == 4'd2) acc_q <= acc_q - term;
				if (step_q == 4'd4) acc_q <= acc_q + term;
				if (step_q == 4'd6) begin
					acc_q  <= acc_q - term;
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	assign det = acc_q;
endmodule
`default_nettype wire

@@ rtl/core/tbl_div.sv @@
`default_nettype none
// Restoring Q16 fraction divider, one quotient bit per cycle.
module tbl_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [tbl_pkg::DetW-1:0]      num,
	input  wire logic [tbl_pkg::DetW-1:0]      den,
	output logic                               done,
	output logic [tbl_pkg::WeightW-1:0]        quo
);
	import tbl_pkg::*;
	logic [DetW:0]   rem_q;
	logic [DetW-1:0] den_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic [DetW:0]   sh;

	assign sh = {rem_q[DetW-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				den_q <= den;
				rem_q <= {1'b0, num};
				quo   <= '0;
				cnt_q <= '0;
				if (num >= den) begin
					quo  <= WeightOne;
					done <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (sh >= {1'b0, den_q}) begin
					rem_q <= sh - {1'b0, den_q};
					quo   <= {quo[WeightW-2:0], 1'b1};
				end else begin
					rem_q <= sh;
					quo   <= {quo[WeightW-2:0], 1'b0};
				end
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/tetrahedron_barycentric_locate.sv @@
`default_nettype none
// Point location in a table of tetrahedra.
// Input stream s_axis: tdata carries tet_slot, corner, vertex_id, pos_x,
// pos_y, pos_z; tuser carries the operation (0 load, 1 query).
// A load writes one corner into the corner memories in the cycle it is accepted.
// Loads of corners 0 to 2 can follow back to back. Writing corner 3 also reads
// the four corners back and computes that slot's determinant. Input is held
// off until the determinant has been written to the volume memory. A load
// yields no output item.
// A query scans slots 0 to min(active_tets, MAX_TETS)-1 and stops at the first
// hit. For each slot it reads the volume; a slot with a zero volume is skipped.
// Any other slot reads the four corners, then computes up to four determinants
// on the shared multiplier unit, each with one corner replaced by the query
// point; a determinant whose sign differs from the volume rejects the slot.
// A hit adds four divisions, one per weight; a weight that saturates at one
// needs no bit-by-bit division. The determinant unit sets the scan rate.
// Output stream m_axis: four items (one per corner, tlast on the fourth) or
// one not-found item. One item at a time; the block holds while m_axis_tready
// is low and accepts no new item until the query is fully delivered.
// Reset clears control and active_tets; memories are undefined until loaded.
module tetrahedron_barycentric_locate
	import tbl_pkg::*;
#(
	parameter int MAX_TETS   = MaxTetsDefault,
	parameter int COORD_BITS = CoordBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tet_slot[7:0], corner[9:8], vertex_id[25:10], pos_x[41:26],
	// pos_y[57:42], pos_z[73:58], zero fill to 80
	input  wire logic [79:0] s_axis_tdata,
	// operation
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// found[0], result_corner[2:1], result_vertex[18:3], weight[35:19], fill to 40
	output logic [39:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int TW = (MAX_TETS > 1) ? $clog2(MAX_TETS) : 1;
	localparam int CW = TW + 2;
	localparam int NW = $clog2(MAX_TETS + 1);
	localparam int DW = COORD_BITS + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LRD, ST_LWAIT, ST_LDET,
		ST_SVOL, ST_SRD, ST_SDET, ST_SNEXT,
		ST_DIV, ST_OUT, ST_NF
	} st_t;
	st_t state_q;

	logic [8:0] active_q;
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {23'd0, active_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) active_q <= '0;
		else if (psel && penable && pwrite && paddr == 3'd0) active_q <= pwdata[8:0];
	end

	wire [7:0]  in_slot   = s_axis_tdata[7:0];
	wire [1:0]  in_corner = s_axis_tdata[9:8];
	wire [15:0] in_vid    = s_axis_tdata[25:10];
	wire signed [COORD_BITS-1:0] in_x = s_axis_tdata[26 +: COORD_BITS];
	wire signed [COORD_BITS-1:0] in_y = s_axis_tdata[42 +: COORD_BITS];
	wire signed [COORD_BITS-1:0] in_z = s_axis_tdata[58 +: COORD_BITS];

	// corner and volume memories
	logic          cwe;
	logic [CW-1:0] cwaddr, craddr;
	logic [COORD_BITS-1:0] rx, ry, rz;
	logic [15:0]   rv;
	logic          vwe;
	logic [TW-1:0] vwaddr, vraddr;
	logic [DetW-1:0] vrd;
	logic signed [DetW-1:0] det;

	tbl_ram #(.Width(COORD_BITS), .Depth(4*MAX_TETS)) u_x (.clk, .we(cwe),
		.waddr(cwaddr), .wdata(in_x), .raddr(craddr), .rdata(rx));
	tbl_ram #(.Width(COORD_BITS), .Depth(4*MAX_TETS)) u_y (.clk, .we(cwe),
		.waddr(cwaddr), .wdata(in_y), .raddr(craddr), .rdata(ry));
	tbl_ram #(.Width(COORD_BITS), .Depth(4*MAX_TETS)) u_z (.clk, .we(cwe),
		.waddr(cwaddr), .wdata(in_z), .raddr(craddr), .rdata(rz));
	tbl_ram #(.Width(16), .Depth(4*MAX_TETS)) u_v (.clk, .we(cwe),
		.waddr(cwaddr), .wdata(in_vid), .raddr(craddr), .rdata(rv));
	tbl_ram #(.Width(DetW), .Depth(MAX_TETS)) u_vol (.clk, .we(vwe),
		.waddr(vwaddr), .wdata(det), .raddr(vraddr), .rdata(vrd));

	// held item and scan state
	logic [TW-1:0] slot_q;
	logic [NW-1:0] tet_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic signed [COORD_BITS-1:0] cx_q [4], cy_q [4], cz_q [4];
	logic [15:0] cv_q [4];
	logic [2:0]  rd_q;
	logic [1:0]  j_q;
	logic signed [DetW-1:0] vol_q;
	logic [DetW-1:0] dets_q [4];
	logic [WeightW-1:0] w_q [4];
	logic det_start, det_done, div_start, div_done;
	logic [WeightW-1:0] quo;
	logic [NW-1:0] n_lim;

	assign n_lim = (32'(active_q) > MAX_TETS) ? NW'(MAX_TETS) : NW'(active_q);

	// determinant inputs: corner j replaced by the query point in scan mode
	logic signed [COORD_BITS-1:0] ux [4], uy [4], uz [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ux[k] = cx_q[k]; uy[k] = cy_q[k]; uz[k] = cz_q[k];
			if (state_q == ST_SDET && j_q == 2'(k)) begin
				ux[k] = px_q; uy[k] = py_q; uz[k] = pz_q;
			end
		end
	end
	tbl_det #(.CoordBits(COORD_BITS)) u_det (.clk, .arst_n, .start(det_start),
		.ax(DW'(ux[1]) - DW'(ux[0])), .ay(DW'(uy[1]) - DW'(uy[0])),
		.az(DW'(uz[1]) - DW'(uz[0])),
		.bx(DW'(ux[2]) - DW'(ux[0])), .by(DW'(uy[2]) - DW'(uy[0])),
		.bz(DW'(uz[2]) - DW'(uz[0])),
		.cx(DW'(ux[3]) - DW'(ux[0])), .cy(DW'(uy[3]) - DW'(uy[0])),
		.cz(DW'(uz[3]) - DW'(uz[0])),
		.done(det_done), .det(det));

	logic [DetW-1:0] mag_d, mag_v;
	assign mag_v = vol_q[DetW-1] ? DetW'(-vol_q) : DetW'(vol_q);
	assign mag_d = dets_q[j_q][DetW-1] ? DetW'(-$signed(dets_q[j_q])) : dets_q[j_q];
	tbl_div u_div (.clk, .arst_n, .start(div_start), .num(mag_d), .den(mag_v),
		.done(div_done), .quo(quo));

	wire s_acc = s_axis_tvalid && s_axis_tready;
	wire m_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cwe    = s_acc && s_axis_tuser == OpLoad && 32'(in_slot) < MAX_TETS;
	assign cwaddr = {TW'(in_slot), in_corner};
	assign craddr = {(state_q == ST_LRD || state_q == ST_LWAIT) ? slot_q : tet_q[TW-1:0],
		rd_q[1:0]};
	assign vraddr = tet_q[TW-1:0];
	assign vwaddr = slot_q;
	assign vwe    = (state_q == ST_LDET) && det_done;
	assign det_start = (state_q == ST_LWAIT && rd_q == 3'd4) ||
		(state_q == ST_SRD && rd_q == 3'd4) ||
		(state_q == ST_SNEXT);
	assign div_start = (state_q == ST_DIV) && !div_done && rd_q == 3'd0;

	wire bad = (det != '0) && (det[DetW-1] != vol_q[DetW-1]);

	// sequencer: load, scan, divide, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
			rd_q <= '0;
			j_q <= '0;
			tet_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_acc) begin
					px_q <= in_x; py_q <= in_y; pz_q <= in_z;
					slot_q <= TW'(in_slot);
					rd_q <= '0;
					tet_q <= '0;
					if (s_axis_tuser == OpQuery) state_q <= ST_SVOL;
					else if (in_corner == 2'd3 && 32'(in_slot) < MAX_TETS)
						state_q <= ST_LRD;
				end
				ST_LRD, ST_SRD, ST_LWAIT: begin
					// stream four corners out of memory
					if (rd_q != 3'd0) begin
						cx_q[rd_q[1:0]-2'd1] <= rx; cy_q[rd_q[1:0]-2'd1] <= ry;
						cz_q[rd_q[1:0]-2'd1] <= rz; cv_q[rd_q[1:0]-2'd1] <= rv;
					end
					rd_q <= rd_q + 3'd1;
					if (rd_q == 3'd4) begin
						rd_q <= '0;
						j_q  <= '0;
						state_q <= (state_q == ST_SRD) ? ST_SDET : ST_LDET;
					end else if (state_q == ST_LRD && rd_q == 3'd3)
						state_q <= ST_LWAIT;
				end
				ST_LDET: if (det_done) state_q <= ST_IDLE;
				ST_SVOL: begin
					if (tet_q >= n_lim) state_q <= ST_NF;
					else if (rd_q == 3'd1) begin
						rd_q <= '0;
						vol_q <= vrd;
						if (vrd == '0) tet_q <= tet_q + NW'(1);
						else state_q <= ST_SRD;
					end else rd_q <= 3'd1;
				end
				ST_SDET: if (det_done) begin
					dets_q[j_q] <= det;
					if (bad) begin
						tet_q <= tet_q + NW'(1);
						rd_q <= '0;
						state_q <= ST_SVOL;
					end else if (j_q == 2'd3) begin
						j_q <= '0;
						rd_q <= '0;
						state_q <= ST_DIV;
					end else begin
						j_q <= j_q + 2'd1;
						state_q <= ST_SNEXT;
					end
				end
				ST_SNEXT: state_q <= ST_SDET;
				ST_DIV: begin
					rd_q <= 3'd1;
					if (div_done) begin
						w_q[j_q] <= (dets_q[j_q] == '0) ? '0 : quo;
						rd_q <= '0;
						if (j_q == 2'd3) begin
							j_q <= '0;
							state_q <= ST_OUT;
						end else j_q <= j_q + 2'd1;
					end
				end
				ST_OUT: begin
					m_axis_tvalid <= 1'b1;
					if (m_acc) begin
						if (j_q == 2'd3) begin
							m_axis_tvalid <= 1'b0;
							state_q <= ST_IDLE;
						end
						j_q <= j_q + 2'd1;
					end
				end
				ST_NF: begin
					m_axis_tvalid <= 1'b1;
					if (m_acc) begin
						m_axis_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	wire hit = (state_q == ST_OUT);
	assign m_axis_tdata = hit ? {4'd0, w_q[j_q], cv_q[j_q], j_q, 1'b1} : 40'd0;
	assign m_axis_tlast = hit ? (j_q == 2'd3) : 1'b1;

	// output only in delivery states
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (state_q == ST_OUT || state_q == ST_NF))
		else $error("output valid outside delivery");
	// no input taken while a load or query is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("ready while busy");
	// volume write only after a corner-3 load
	assert property (@(posedge clk) disable iff (!arst_n)
		vwe |-> state_q == ST_LDET)
		else $error("stray volume write");
endmodule
`default_nettype wire
